[src/sm3_hash_engine_top_macros.svh]
// Assertion macros for the hash engine. Each one samples on clk and is
// disabled while arst_n is low.
`ifndef SM3_HASH_ENGINE_TOP_MACROS_SVH
`define SM3_HASH_ENGINE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define SM3_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sm3 assertion failed");

// Next-cycle implication.
`define SM3_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sm3 assertion failed");

`else

`define SM3_ASSERT_NOW(lbl, ante, cons)
`define SM3_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[src/sm3_pkg.sv]
`default_nettype none

package sm3_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [31:0] TJ_LOW  = 32'h79cc4519;
	localparam logic [31:0] TJ_HIGH = 32'h7a879d8a;
	localparam logic [7:0]  PAD_BYTE = 8'd128;

	localparam logic [0:7][31:0] IV = {
		32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
		32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
	};

	// One 512-bit message block on its way to the compression engine.
	typedef struct packed {
		logic             last;
		logic [0:15][31:0] words;
	} blk_t;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] dbl;
		dbl = {x, x};
		return dbl[6'd63 - {1'b0, n} -: 32];
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] x);
		return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] x);
		return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
	endfunction

endpackage

`default_nettype wire

[src/sm3_hash_engine_top.sv]
`default_nettype none
// Channel   Signals                                      Request
// -------   ------------------------------------------   -----------------------------
// in        in_valid, in_ready, data_word, valid_bytes,   one message chunk of 0..4
//           final_chunk                                   bytes
// out       out_valid, out_ready, digest_word,            one digest word, eight per
//           word_index, last_word                         message
//
// The front takes one chunk per cycle while in_ready is high; a final chunk adds
// padding and length insertion (F_PAD, F_LEN) before the next chunk is taken.
// Each 512-bit block holds the compression engine through a load, 64 rounds at
// one per cycle and a chaining fold. A final block then also holds it while its
// eight digest words go out, longer while out_ready is low. The block queue lets
// the front keep packing while the engine is busy; the front also stalls while a
// full block waits to be pushed into the queue. Reset loads the IV at once.

`include "sm3_hash_engine_top_macros.svh"

module sm3_hash_engine_top #(
	parameter int QUEUE_DEPTH = sm3_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] data_word,
	input  wire logic [2:0]  valid_bytes,
	input  wire logic        final_chunk,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);

	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_valid;
	sm3_pkg::blk_t q_in;
	sm3_pkg::blk_t q_out;

	sm3_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_word   (data_word),
		.valid_bytes (valid_bytes),
		.final_chunk (final_chunk),
		.q_push      (q_push),
		.q_data      (q_in),
		.q_full      (q_full)
	);

	sm3_queue #(
		.WIDTH ($bits(sm3_pkg::blk_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.not_empty (q_valid)
	);

	sm3_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_data      (q_out),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	// The front must never offer a block the queue cannot take.
	`SM3_ASSERT_NOW(a_no_push_when_full, q_push, !q_full)
	// A final chunk always stalls the input while padding is inserted.
	`SM3_ASSERT_NEXT(a_final_stalls, in_valid && in_ready && final_chunk, !in_ready)
	// Digest words go out as one unbroken, ordered burst.
	`SM3_ASSERT_NEXT(a_digest_burst, out_valid && out_ready && !last_word, out_valid && (word_index == $past(word_index) + 3'd1))

endmodule

`default_nettype wire

[src/sm3_front.sv]
`default_nettype none

module sm3_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [31:0]   data_word,
	input  wire logic [2:0]    valid_bytes,
	input  wire logic          final_chunk,
	output logic               q_push,
	output sm3_pkg::blk_t      q_data,
	input  wire logic          q_full
);

	typedef enum logic [1:0] {F_IDLE, F_PAD, F_LEN} state_t;

	state_t            state_q;
	logic [0:15][31:0] buf_q;
	logic [3:0]        wcount_q;
	logic              full_q;
	logic [31:0]       partial_q;
	logic [1:0]        pbytes_q;
	logic [63:0]       msg_bits_q;
	logic [63:0]       len_q;

	logic [2:0]        nb;
	logic [31:0]       keep_mask;
	logic [63:0]       joined;
	logic [2:0]        total;
	logic [31:0]       pad_word;
	logic              accept;
	logic              wr_en;
	logic [31:0]       wr_word;
	logic              flush_go;
	logic              len_go;
	sm3_pkg::blk_t     len_blk;

	assign nb        = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
	assign keep_mask = ~(32'hffffffff >> {nb, 3'b000});
	assign joined    = {partial_q, 32'h0} | ({data_word & keep_mask, 32'h0} >> {pbytes_q, 3'b000});
	assign total     = {1'b0, pbytes_q} + nb;
	assign pad_word  = partial_q | ({sm3_pkg::PAD_BYTE, 24'h0} >> {pbytes_q, 3'b000});

	assign in_ready = (state_q == F_IDLE) && !full_q;
	assign accept   = in_valid && in_ready;
	assign wr_en    = (accept && total[2]) || ((state_q == F_PAD) && !full_q);
	assign wr_word  = (state_q == F_PAD) ? pad_word : joined[63:32];

	assign flush_go = full_q && !q_full;
	assign len_go   = (state_q == F_LEN) && !full_q && !q_full;
	assign q_push   = flush_go || len_go;

	always_comb begin
		len_blk           = '0;
		len_blk.last      = 1'b1;
		len_blk.words     = buf_q;
		len_blk.words[14] = len_q[63:32];
		len_blk.words[15] = len_q[31:0];
	end

	// With fifteen words held there is no room for the length, so that block
	// goes out with a zero last word and the length follows in a fresh one.
	always_comb begin
		if (flush_go || (wcount_q == 4'd15)) begin
			q_data.last  = 1'b0;
			q_data.words = buf_q;
		end else begin
			q_data = len_blk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			buf_q      <= '0;
			wcount_q   <= '0;
			full_q     <= 1'b0;
			partial_q  <= '0;
			pbytes_q   <= '0;
			msg_bits_q <= '0;
			len_q      <= '0;
		end else begin
			if (accept) begin
				partial_q  <= total[2] ? joined[31:0] : joined[63:32];
				pbytes_q   <= total[1:0];
				if (final_chunk) begin
					len_q      <= msg_bits_q + {58'd0, nb, 3'b000};
					msg_bits_q <= '0;
					state_q    <= F_PAD;
				end else begin
					msg_bits_q <= msg_bits_q + {58'd0, nb, 3'b000};
				end
			end
			if ((state_q == F_PAD) && !full_q) begin
				partial_q <= '0;
				pbytes_q  <= '0;
				state_q   <= F_LEN;
			end
			if (wr_en) begin
				buf_q[wcount_q] <= wr_word;
				wcount_q        <= wcount_q + 4'd1;
				if (wcount_q == 4'd15) begin
					full_q <= 1'b1;
				end
			end
			if (q_push) begin
				buf_q    <= '0;
				wcount_q <= '0;
				full_q   <= 1'b0;
				if (len_go && (wcount_q != 4'd15)) begin
					state_q <= F_IDLE;
				end
			end
		end
	end

endmodule

`default_nettype wire

[src/sm3_queue.sv]
`default_nettype none

module sm3_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

[src/sm3_back.sv]
`default_nettype none

module sm3_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  wire sm3_pkg::blk_t q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [31:0]        digest_word,
	output logic [2:0]         word_index,
	output logic               last_word
);

	typedef enum logic [1:0] {B_IDLE, B_ROUND, B_FOLD, B_OUT} state_t;

	state_t            state_q;
	logic [0:7][31:0]  chain_q;
	logic [0:7][31:0]  v_q;
	logic [0:15][31:0] win_q;
	logic [5:0]        round_q;
	logic              final_q;
	logic [2:0]        out_idx_q;

	logic [31:0] a12, tj, ss1, ss2, ff, gg, tt1, tt2, w_new;
	logic        early;

	assign early = (round_q[5:4] == 2'b00);
	assign tj    = early ? sm3_pkg::TJ_LOW : sm3_pkg::TJ_HIGH;
	assign a12   = sm3_pkg::rotl32(v_q[0], 5'd12);
	assign ss1   = sm3_pkg::rotl32(a12 + v_q[4] + sm3_pkg::rotl32(tj, round_q[4:0]), 5'd7);
	assign ss2   = ss1 ^ a12;
	assign ff    = early ? (v_q[0] ^ v_q[1] ^ v_q[2])
	                     : ((v_q[0] & v_q[1]) | (v_q[0] & v_q[2]) | (v_q[1] & v_q[2]));
	assign gg    = early ? (v_q[4] ^ v_q[5] ^ v_q[6])
	                     : ((v_q[4] & v_q[5]) | (~v_q[4] & v_q[6]));
	assign tt1   = ff + v_q[3] + ss2 + (win_q[0] ^ win_q[4]);
	assign tt2   = gg + v_q[7] + ss1 + win_q[0];

	// The window holds W[j] .. W[j+15]; each round appends W[j+16].
	assign w_new = sm3_pkg::perm1(win_q[0] ^ win_q[7] ^ sm3_pkg::rotl32(win_q[13], 5'd15))
	             ^ sm3_pkg::rotl32(win_q[3], 5'd7) ^ win_q[10];

	assign q_pop       = (state_q == B_IDLE) && q_valid;
	assign out_valid   = (state_q == B_OUT);
	assign digest_word = chain_q[out_idx_q];
	assign word_index  = out_idx_q;
	assign last_word   = (out_idx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			chain_q   <= sm3_pkg::IV;
			v_q       <= '0;
			win_q     <= '0;
			round_q   <= '0;
			final_q   <= 1'b0;
			out_idx_q <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						win_q   <= q_data.words;
						v_q     <= chain_q;
						final_q <= q_data.last;
						round_q <= '0;
						state_q <= B_ROUND;
					end
				end
				B_ROUND: begin
					v_q[0] <= tt1;
					v_q[1] <= v_q[0];
					v_q[2] <= sm3_pkg::rotl32(v_q[1], 5'd9);
					v_q[3] <= v_q[2];
					v_q[4] <= sm3_pkg::perm0(tt2);
					v_q[5] <= v_q[4];
					v_q[6] <= sm3_pkg::rotl32(v_q[5], 5'd19);
					v_q[7] <= v_q[6];
					for (int i = 0; i < 15; i++) begin
						win_q[i] <= win_q[i+1];
					end
					win_q[15] <= w_new;
					round_q   <= round_q + 6'd1;
					if (round_q == 6'd63) begin
						state_q <= B_FOLD;
					end
				end
				B_FOLD: begin
					chain_q   <= chain_q ^ v_q;
					out_idx_q <= '0;
					state_q   <= final_q ? B_OUT : B_IDLE;
				end
				B_OUT: begin
					if (out_ready) begin
						if (out_idx_q == 3'd7) begin
							chain_q <= sm3_pkg::IV;
							state_q <= B_IDLE;
						end else begin
							out_idx_q <= out_idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[tb/sm3_hash_engine_top_tb.sv]
`default_nettype none

module sm3_hash_engine_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAND_CHUNKS = 500;
	localparam int HOLD_AT = 60;
	localparam int HOLD_CYCLES = 2500;
	localparam int TAIL_CYCLES = 100;
	localparam int LIMIT_CYCLES = 400000;

	typedef struct packed {
		logic [31:0] data;
		logic [2:0]  nbytes;
		logic        fin;
	} chunk_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] data_word = '0;
	logic [2:0]  valid_bytes = '0;
	logic        final_chunk = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	chunk_t  chunk_q[$];
	digest_t digest_q[$];

	// Hash state mirrored from the block.
	logic [31:0] hv[8];
	logic [31:0] bw[16];
	logic [31:0] pw;
	logic [1:0]  pb;
	logic [3:0]  wc;
	logic [63:0] nbits;

	logic   in_taken = 1'b0;
	logic   out_taken = 1'b0;
	int     chunks_in = 0;
	int     chunks_added = 0;
	int     errors = 0;
	chunk_t tx_next;
	bit     tx_have = 1'b0;
	int     tx_wait = 0;
	int     tx_burst = 0;
	int     rx_wait = 0;
	int     rx_burst = 0;
	bit     hold_done = 1'b0;

	sm3_hash_engine_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_word(data_word),
		.valid_bytes(valid_bytes),
		.final_chunk(final_chunk),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.digest_word(digest_word),
		.word_index(word_index),
		.last_word(last_word)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [31:0] rol(input logic [31:0] x, input int n);
		return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
	endfunction

	function automatic logic [31:0] sm3_p0(input logic [31:0] x);
		return x ^ rol(x, 9) ^ rol(x, 17);
	endfunction

	function automatic logic [31:0] sm3_p1(input logic [31:0] x);
		return x ^ rol(x, 15) ^ rol(x, 23);
	endfunction

	task automatic hash_init();
		for (int k = 0; k < 8; k++) hv[k] = sm3_pkg::IV[k];
		for (int k = 0; k < 16; k++) bw[k] = '0;
		pw = '0;
		pb = '0;
		wc = '0;
		nbits = '0;
	endtask

	task automatic compress_blk();
		logic [31:0] w[68];
		logic [31:0] wp[64];
		logic [31:0] v[8];
		logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2;
		for (int j = 0; j < 16; j++) w[j] = bw[j];
		for (int j = 16; j < 68; j++) begin
			w[j] = sm3_p1(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
		end
		for (int j = 0; j < 64; j++) wp[j] = w[j] ^ w[j+4];
		for (int k = 0; k < 8; k++) v[k] = hv[k];
		for (int j = 0; j < 64; j++) begin
			tj = (j < 16) ? sm3_pkg::TJ_LOW : sm3_pkg::TJ_HIGH;
			a12 = rol(v[0], 12);
			ss1 = rol(a12 + v[4] + rol(tj, j % 32), 7);
			ss2 = ss1 ^ a12;
			if (j < 16) begin
				ff = v[0] ^ v[1] ^ v[2];
				gg = v[4] ^ v[5] ^ v[6];
			end else begin
				ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
				gg = (v[4] & v[5]) | (~v[4] & v[6]);
			end
			tt1 = ff + v[3] + ss2 + wp[j];
			tt2 = gg + v[7] + ss1 + w[j];
			v[3] = v[2];
			v[2] = rol(v[1], 9);
			v[1] = v[0];
			v[0] = tt1;
			v[7] = v[6];
			v[6] = rol(v[5], 19);
			v[5] = v[4];
			v[4] = sm3_p0(tt2);
		end
		for (int k = 0; k < 8; k++) hv[k] = hv[k] ^ v[k];
		for (int k = 0; k < 16; k++) bw[k] = '0;
		wc = '0;
	endtask

	task automatic put_word(input logic [31:0] wd);
		bw[wc] = wd;
		wc = wc + 4'd1;
		if (wc == 4'd0) compress_blk();
	endtask

	task automatic put_byte(input logic [7:0] b);
		pw[31 - 8 * int'(pb) -: 8] = b;
		pb = pb + 2'd1;
		if (pb == 2'd0) begin
			put_word(pw);
			pw = '0;
		end
	endtask

	// Absorbs one chunk; a final chunk pads, finishes and queues the digest.
	task automatic predict_chunk(input logic [31:0] data, input logic [2:0] nb, input logic fin);
		int n;
		logic [63:0] len;
		n = (nb > 3'd4) ? 4 : int'(nb);
		for (int i = 0; i < n; i++) begin
			put_byte(data[31 - 8 * i -: 8]);
			nbits = nbits + 64'd8;
		end
		if (fin) begin
			len = nbits;
			put_byte(sm3_pkg::PAD_BYTE);
			while (pb != 2'd0) put_byte(8'h00);
			// No room left for the length words: it goes into an extra block.
			if (wc == 4'd15) compress_blk();
			bw[14] = len[63:32];
			bw[15] = len[31:0];
			compress_blk();
			for (int k = 0; k < 8; k++) begin
				digest_q.push_back('{word: hv[k], idx: 3'(k), last: (k == 7)});
			end
			hash_init();
		end
	endtask

	task automatic add_chunk(input logic [31:0] data, input logic [2:0] nb, input logic fin);
		chunk_q.push_back('{data: data, nbytes: nb, fin: fin});
		chunks_added++;
	endtask

	// Splits a message into chunks of random size, with some empty chunks and
	// oversized byte counts mixed in.
	task automatic add_message(input int len);
		int left, k, nb;
		bit fin_empty;
		fin_empty = (len == 0) || ($urandom_range(0, 5) == 0);
		left = len;
		while (left > 0) begin
			if ($urandom_range(0, 15) == 0) add_chunk($urandom, 3'd0, 1'b0);
			k = $urandom_range(1, 4);
			if (k > left) k = left;
			nb = k;
			if (k == 4 && $urandom_range(0, 3) == 0) nb = $urandom_range(5, 7);
			left -= k;
			add_chunk($urandom, 3'(nb), (left == 0) && !fin_empty);
		end
		if (fin_empty) add_chunk($urandom, 3'd0, 1'b1);
	endtask

	always @(posedge clk) begin
		digest_t exp_d;
		in_taken <= in_valid && in_ready;
		out_taken <= out_valid && out_ready;
		if (arst_n && in_valid && in_ready) begin
			chunks_in <= chunks_in + 1;
			predict_chunk(data_word, valid_bytes, final_chunk);
		end
		if (arst_n && out_valid && out_ready) begin
			if (digest_q.size() == 0) begin
				errors++;
				$display("%0t: digest word %h (index %0d) arrived with no digest pending",
					$time, digest_word, word_index);
			end else begin
				exp_d = digest_q.pop_front();
				if (digest_word !== exp_d.word) begin
					errors++;
					$display("%0t: digest_word expected %h actual %h",
						$time, exp_d.word, digest_word);
				end
				if (word_index !== exp_d.idx) begin
					errors++;
					$display("%0t: word_index expected %0d actual %0d",
						$time, exp_d.idx, word_index);
				end
				if (last_word !== exp_d.last) begin
					errors++;
					$display("%0t: last_word expected %b actual %b",
						$time, exp_d.last, last_word);
				end
			end
		end
	end

	// Request driver: holds a request until it is taken, then waits a drawn gap.
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_taken)) begin
			if (!tx_have && chunk_q.size() != 0) begin
				tx_next = chunk_q.pop_front();
				tx_have = 1'b1;
				if (tx_burst > 0) begin
					tx_burst--;
					tx_wait = 0;
				end else if ($urandom_range(0, 15) == 0) begin
					tx_burst = $urandom_range(20, 60);
					tx_wait = 0;
				end else begin
					tx_wait = $urandom_range(0, 19);
				end
			end
			if (tx_have && tx_wait == 0) begin
				in_valid <= 1'b1;
				data_word <= tx_next.data;
				valid_bytes <= tx_next.nbytes;
				final_chunk <= tx_next.fin;
				tx_have = 1'b0;
			end else begin
				in_valid <= 1'b0;
				if (tx_have) tx_wait--;
			end
		end
	end

	// Digest receiver. Once, it stops taking words for a long stretch so that
	// the block queue fills and the input side stalls.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && chunks_in >= HOLD_AT) begin
				hold_done = 1'b1;
				rx_wait = HOLD_CYCLES;
			end else if (out_taken) begin
				if (rx_burst > 0) begin
					rx_burst--;
					rx_wait = 0;
				end else if ($urandom_range(0, 15) == 0) begin
					rx_burst = $urandom_range(20, 60);
					rx_wait = 0;
				end else begin
					rx_wait = $urandom_range(0, 19);
				end
			end
			if (rx_wait > 0) begin
				out_ready <= 1'b0;
				rx_wait--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int sel, len;
		hash_init();

		add_chunk($urandom, 3'd0, 1'b1);
		add_chunk(32'h61626300, 3'd3, 1'b1);
		add_chunk(32'hffffffff, 3'd7, 1'b0);
		add_chunk(32'h00000000, 3'd5, 1'b0);
		add_chunk(32'h80000001, 3'd6, 1'b1);
		add_chunk($urandom, 3'd0, 1'b0);
		add_chunk(32'h12345678, 3'd4, 1'b1);
		add_chunk(32'haa55aa55, 3'd1, 1'b0);
		add_chunk(32'h55aa55aa, 3'd2, 1'b0);
		add_chunk(32'hdeadbeef, 3'd3, 1'b0);
		add_chunk($urandom, 3'd0, 1'b1);
		// Fourteen full words: the length spills into a second block.
		for (int i = 0; i < 14; i++) add_chunk($urandom, 3'd4, i == 13);

		while (chunks_added < RAND_CHUNKS + 25) begin
			sel = $urandom_range(0, 9);
			if (sel < 5) len = $urandom_range(0, 20);
			else if (sel < 8) len = 64 * $urandom_range(0, 1) + $urandom_range(52, 64);
			else if (sel == 8) len = $urandom_range(65, 140);
			else len = $urandom_range(0, 255);
			add_message(len);
		end

		repeat (7) @(posedge clk);
		#1 arst_n = 1'b1;

		do begin
			@(posedge clk);
			#1;
		end while (chunk_q.size() != 0 || tx_have || in_valid || digest_q.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
